/* rtl/rv64alu_pkg.sv */
package rv64alu_pkg;

    // Operation codes carried in the opcode field.
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_AND   = 4'd2,
        OP_OR    = 4'd3,
        OP_XOR   = 4'd4,
        OP_SLL   = 4'd5,
        OP_SRL   = 4'd6,
        OP_MUL   = 4'd7,
        OP_MULH  = 4'd8,
        OP_MULHU = 4'd9,
        OP_ADDI  = 4'd10,
        OP_ADDIW = 4'd11,
        OP_ANDI  = 4'd12,
        OP_SLLI  = 4'd13,
        OP_SRLI  = 4'd14,
        OP_LUI   = 4'd15
    } t_op;

    localparam int XLEN     = 64;
    localparam int HALF     = 32;
    localparam int IMM_W    = 20;
    localparam int IMM12_W  = 12;
    localparam int SHAMT_W  = 6;

    // One input item.
    typedef struct packed {
        t_op                      opcode;
        logic signed [XLEN-1:0]   first_operand;
        logic signed [XLEN-1:0]   second_operand;
        logic signed [IMM_W-1:0]  immediate;
    } t_alu_in;

    // One result item.
    typedef struct packed {
        logic signed [XLEN-1:0] result;
        logic                   immediate_out_of_range;
    } t_alu_out;

    // Result of the combinational operations.
    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            flag;
    } t_simple_res;

    // Result of the multiplier pipeline.
    typedef struct packed {
        logic [XLEN-1:0] lo;
        logic [XLEN-1:0] hi_unsigned;
        logic [XLEN-1:0] hi_signed;
    } t_mul_res;

endpackage

/* rtl/rv64alu_exec.sv */
module rv64alu_exec (
    input  rv64alu_pkg::t_op                     i_op,
    input  logic [rv64alu_pkg::XLEN-1:0]         i_a,
    input  logic [rv64alu_pkg::XLEN-1:0]         i_b,
    input  logic [rv64alu_pkg::IMM_W-1:0]        i_imm,
    output rv64alu_pkg::t_simple_res             o_res
);

    logic [rv64alu_pkg::XLEN-1:0]    imm12;
    logic [rv64alu_pkg::XLEN-1:0]    sum_i;
    logic [rv64alu_pkg::XLEN-1:0]    lui_val;
    logic [rv64alu_pkg::SHAMT_W-1:0] sh_reg;
    logic [rv64alu_pkg::SHAMT_W-1:0] sh_imm;
    logic                            wide;

    // Immediate forms: sign-extended low 12 bits, and the upper immediate.
    assign imm12   = {{(rv64alu_pkg::XLEN-rv64alu_pkg::IMM12_W){i_imm[rv64alu_pkg::IMM12_W-1]}},
                      i_imm[rv64alu_pkg::IMM12_W-1:0]};
    assign lui_val = {{(rv64alu_pkg::HALF){i_imm[rv64alu_pkg::IMM_W-1]}}, i_imm, 12'b0};
    assign sum_i   = i_a + imm12;
    assign sh_reg  = i_b[rv64alu_pkg::SHAMT_W-1:0];
    assign sh_imm  = i_imm[rv64alu_pkg::SHAMT_W-1:0];

    // The immediate fits 12 signed bits when its upper bits all match bit 11.
    assign wide = !((i_imm[rv64alu_pkg::IMM_W-1:rv64alu_pkg::IMM12_W-1] == '0) ||
                    (i_imm[rv64alu_pkg::IMM_W-1:rv64alu_pkg::IMM12_W-1] == '1));

    // Operation select; the multiply codes are filled in later by the top level.
    always_comb begin
        o_res.value = '0;
        o_res.flag  = 1'b0;
        unique case (i_op)
            rv64alu_pkg::OP_ADD:   o_res.value = i_a + i_b;
            rv64alu_pkg::OP_SUB:   o_res.value = i_a - i_b;
            rv64alu_pkg::OP_AND:   o_res.value = i_a & i_b;
            rv64alu_pkg::OP_OR:    o_res.value = i_a | i_b;
            rv64alu_pkg::OP_XOR:   o_res.value = i_a ^ i_b;
            rv64alu_pkg::OP_SLL:   o_res.value = i_a << sh_reg;
            rv64alu_pkg::OP_SRL:   o_res.value = i_a >> sh_reg;
            rv64alu_pkg::OP_MUL,
            rv64alu_pkg::OP_MULH,
            rv64alu_pkg::OP_MULHU: o_res.value = '0;
            rv64alu_pkg::OP_ADDI: begin
                o_res.value = sum_i;
                o_res.flag  = wide;
            end
            rv64alu_pkg::OP_ADDIW: begin
                o_res.value = {{(rv64alu_pkg::HALF){sum_i[rv64alu_pkg::HALF-1]}},
                               sum_i[rv64alu_pkg::HALF-1:0]};
                o_res.flag  = wide;
            end
            rv64alu_pkg::OP_ANDI: begin
                o_res.value = i_a & imm12;
                o_res.flag  = wide;
            end
            rv64alu_pkg::OP_SLLI:  o_res.value = i_a << sh_imm;
            rv64alu_pkg::OP_SRLI:  o_res.value = i_a >> sh_imm;
            rv64alu_pkg::OP_LUI:   o_res.value = lui_val;
            default:               o_res.value = '0;
        endcase
    end

endmodule

/* rtl/rv64alu_mul.sv */
module rv64alu_mul (
    input  logic                          i_clk,
    input  logic [rv64alu_pkg::XLEN-1:0]  i_a,
    input  logic [rv64alu_pkg::XLEN-1:0]  i_b,
    output rv64alu_pkg::t_mul_res         o_res
);

    localparam int H = rv64alu_pkg::HALF;
    localparam int W = rv64alu_pkg::XLEN;

    logic [W-1:0]   r_ll, r_lh, r_hl, r_hh, r_corr;
    logic [W-1:0]   n_corr;
    logic [H+1:0]   n_mid;
    logic [W-1:0]   r_lo, r_hipart, r_corr2;
    logic [1:0]     r_carry;
    logic [W-1:0]   hu;

    // Signed high-half correction: subtract each operand when the other is negative.
    assign n_corr = (i_a[W-1] ? i_b : '0) + (i_b[W-1] ? i_a : '0);

    // First stage: four 32x32 partial products.
    always_ff @(posedge i_clk) begin
        r_ll   <= i_a[H-1:0] * i_b[H-1:0];
        r_lh   <= i_a[H-1:0] * i_b[W-1:H];
        r_hl   <= i_a[W-1:H] * i_b[H-1:0];
        r_hh   <= i_a[W-1:H] * i_b[W-1:H];
        r_corr <= n_corr;
    end

    // Middle column sum; its carry goes into the high half.
    assign n_mid = {2'b0, r_ll[W-1:H]} + {2'b0, r_lh[H-1:0]} + {2'b0, r_hl[H-1:0]};

    // Second stage: low word and the high word before the middle carry.
    always_ff @(posedge i_clk) begin
        r_lo     <= {n_mid[H-1:0], r_ll[H-1:0]};
        r_hipart <= r_hh + {{H{1'b0}}, r_lh[W-1:H]} + {{H{1'b0}}, r_hl[W-1:H]};
        r_carry  <= n_mid[H+1:H];
        r_corr2  <= r_corr;
    end

    // Final high words, registered by the top level.
    assign hu                = r_hipart + {{(W-2){1'b0}}, r_carry};
    assign o_res.lo          = r_lo;
    assign o_res.hi_unsigned = hu;
    assign o_res.hi_signed   = hu - r_corr2;

endmodule

/* rtl/rv64_integer_alu.sv */
// RV64 integer ALU. An item (opcode, two 64-bit operands and a 20-bit
// immediate) is taken at each clock edge where start is high; busy is always
// low, so a new item may enter every cycle. Every item gives one result on
// o_item, marked by o_done for one cycle. The multiplier path runs through an
// input register, one stage of 32x32 partial products, one stage of column
// sums, and the output register, in front of which the high word is completed
// and the result selected. The other operations are delayed to match the
// multiplier so that results leave in the order items came in. The receiver
// cannot stall the block; each result must be taken in the cycle it appears.
module rv64_integer_alu (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rv64alu_pkg::t_alu_in  i_item,
    output logic                  o_done,
    output rv64alu_pkg::t_alu_out o_item
);

    logic                               r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    rv64alu_pkg::t_op                   r_s1_op, r_s2_op, r_s3_op;
    logic [rv64alu_pkg::XLEN-1:0]       r_s1_a, r_s1_b;
    logic [rv64alu_pkg::IMM_W-1:0]      r_s1_imm;
    rv64alu_pkg::t_simple_res           n_s2_res, r_s2_res, r_s3_res;
    rv64alu_pkg::t_mul_res              mul_res;
    rv64alu_pkg::t_alu_out              n_out, r_out;

    // The pipeline never holds an item back.
    assign busy = 1'b0;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= start && !busy;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        r_s1_op  <= i_item.opcode;
        r_s1_a   <= i_item.first_operand;
        r_s1_b   <= i_item.second_operand;
        r_s1_imm <= i_item.immediate;
    end

    rv64alu_exec u_exec (
        .i_op  (r_s1_op),
        .i_a   (r_s1_a),
        .i_b   (r_s1_b),
        .i_imm (r_s1_imm),
        .o_res (n_s2_res)
    );

    rv64alu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_s1_a),
        .i_b   (r_s1_b),
        .o_res (mul_res)
    );

    // Combinational results wait two stages for the multiplier.
    always_ff @(posedge i_clk) begin
        r_s2_op  <= r_s1_op;
        r_s2_res <= n_s2_res;
        r_s3_op  <= r_s2_op;
        r_s3_res <= r_s2_res;
    end

    // Output select between the multiplier and the other operations.
    always_comb begin
        n_out.immediate_out_of_range = r_s3_res.flag;
        unique case (r_s3_op)
            rv64alu_pkg::OP_MUL:   n_out.result = mul_res.lo;
            rv64alu_pkg::OP_MULH:  n_out.result = mul_res.hi_signed;
            rv64alu_pkg::OP_MULHU: n_out.result = mul_res.hi_unsigned;
            default:               n_out.result = r_s3_res.value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_out_valid;
    assign o_item = r_out;

    // Every accepted item comes out, marked by o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("accepted item did not produce a result after four cycles");

    // The range flag belongs to the immediate-form arithmetic operations only.
    a_flag_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_item.immediate_out_of_range) |->
        ($past(i_item.opcode, 4) == rv64alu_pkg::OP_ADDI ||
         $past(i_item.opcode, 4) == rv64alu_pkg::OP_ADDIW ||
         $past(i_item.opcode, 4) == rv64alu_pkg::OP_ANDI))
        else $error("range flag raised for an operation without an I-type immediate");

    // An upper-immediate result has its low twelve bits clear.
    a_lui_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.opcode, 4) == rv64alu_pkg::OP_LUI) |->
        (o_item.result[11:0] == 12'd0))
        else $error("upper-immediate result has low bits set");

endmodule

/* verif/tb_rv64_integer_alu.sv */
`timescale 1ns / 100ps

module tb_rv64_integer_alu;
    import rv64alu_pkg::*;

    localparam logic [63:0] WORD_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] WORD_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WORD_ONES = 64'hffff_ffff_ffff_ffff;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 1000;

    // Expected ALU results, kept in the order items were accepted.
    class alu_scoreboard;
        t_alu_out pending_results[$];
        int unsigned checked;
        int unsigned flagged;
        int unsigned mismatches;

        // Destination value and range flag for one item.
        function automatic t_alu_out alu_result_of(t_alu_in it);
            t_alu_out r;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] imm12;
            logic [63:0] sum;
            logic [127:0] prod_u;
            logic signed [127:0] prod_s;
            logic wide;
            a = it.first_operand;
            b = it.second_operand;
            imm12 = {{52{it.immediate[11]}}, it.immediate[11:0]};
            // The immediate fits 12 signed bits only if bits 19..11 all agree.
            wide = it.immediate[19:11] != {9{it.immediate[11]}};
            prod_u = {64'b0, a} * {64'b0, b};
            prod_s = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
            r.immediate_out_of_range = 1'b0;
            case (it.opcode)
                OP_ADD:   r.result = a + b;
                OP_SUB:   r.result = a - b;
                OP_AND:   r.result = a & b;
                OP_OR:    r.result = a | b;
                OP_XOR:   r.result = a ^ b;
                OP_SLL:   r.result = a << b[5:0];
                OP_SRL:   r.result = a >> b[5:0];
                OP_MUL:   r.result = prod_u[63:0];
                OP_MULH:  r.result = prod_s[127:64];
                OP_MULHU: r.result = prod_u[127:64];
                OP_ADDI: begin
                    r.result = a + imm12;
                    r.immediate_out_of_range = wide;
                end
                OP_ADDIW: begin
                    sum = a + imm12;
                    r.result = {{32{sum[31]}}, sum[31:0]};
                    r.immediate_out_of_range = wide;
                end
                OP_ANDI: begin
                    r.result = a & imm12;
                    r.immediate_out_of_range = wide;
                end
                OP_SLLI:  r.result = a << it.immediate[5:0];
                OP_SRLI:  r.result = a >> it.immediate[5:0];
                // Load upper immediate.
                default:  r.result = {{32{it.immediate[19]}}, it.immediate, 12'b0};
            endcase
            return r;
        endfunction

        function void note_item(t_alu_in it);
            pending_results.push_back(alu_result_of(it));
        endfunction

        function void check_result(t_alu_out got);
            t_alu_out want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %h/%b arrived with no item pending",
                             $realtime, got.result, got.immediate_out_of_range);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.immediate_out_of_range)
                flagged++;
            if (got.result !== want.result ||
                got.immediate_out_of_range !== want.immediate_out_of_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected result %h flag %b, got result %h flag %b",
                             $realtime, want.result, want.immediate_out_of_range,
                             got.result, got.immediate_out_of_range);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_item;
    logic     o_done;
    t_alu_out o_item;

    alu_scoreboard sb;
    int unsigned items_sent;
    int unsigned directed_items;
    int unsigned stall_cycles;

    rv64_integer_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // Watch both sides of the block and stop a run that has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if (o_done)
                sb.check_result(o_item);
            if (start && !busy)
                sb.note_item(i_item);
            if (o_done || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_alu_in make_item(t_op op, logic [63:0] a, logic [63:0] b,
                                          logic [19:0] imm);
        t_alu_in it;
        it.opcode = op;
        it.first_operand = a;
        it.second_operand = b;
        it.immediate = imm;
        return it;
    endfunction

    // Operands lean toward the corners of the 64-bit range.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORD_ONES;
            2: return WORD_MIN;
            3: return WORD_MAX;
            4: return 64'($urandom_range(0, 63));
            5: return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly in-range 12-bit immediates, with boundaries and full 20-bit values.
    function automatic logic [19:0] rand_immediate();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return r[19:0];
            1: begin
                case (r[1:0])
                    2'd0: return 20'h007ff;
                    2'd1: return 20'hff800;
                    2'd2: return 20'h00800;
                    default: return 20'hff7ff;
                endcase
            end
            default: return {{8{r[11]}}, r[11:0]};
        endcase
    endfunction

    // Offer one item after an optional gap and hold it until it is taken.
    task automatic send_item(input t_alu_in it, input bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Stop offering items until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        start <= 1'b0;
        i_item <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: corners of each operation and the special cases.
        send_item(make_item(OP_ADD, WORD_MAX, 64'd1, 20'h0), 1'b0);
        send_item(make_item(OP_ADD, WORD_MIN, WORD_ONES, 20'hfffff), 1'b0);
        send_item(make_item(OP_SUB, WORD_MIN, 64'd1, 20'h0), 1'b1);
        send_item(make_item(OP_AND, WORD_ONES, 64'h5555_5555_5555_5555, 20'h0), 1'b0);
        send_item(make_item(OP_OR, 64'haaaa_0000_aaaa_0000, 64'h0000_5555_0000_5555,
                            20'h0), 1'b1);
        send_item(make_item(OP_XOR, WORD_ONES, WORD_MAX, 20'h0), 1'b0);
        // Register shifts use only the low six bits of the second operand.
        send_item(make_item(OP_SLL, 64'd1, WORD_ONES, 20'h0), 1'b0);
        send_item(make_item(OP_SLL, WORD_ONES, 64'd64, 20'h0), 1'b1);
        send_item(make_item(OP_SRL, WORD_MIN, 64'hffff_ffff_ffff_ffbf, 20'h0), 1'b0);
        send_item(make_item(OP_MUL, WORD_MAX, WORD_MAX, 20'h0), 1'b0);
        send_item(make_item(OP_MULH, WORD_MIN, WORD_MIN, 20'h0), 1'b1);
        send_item(make_item(OP_MULH, WORD_MIN, WORD_ONES, 20'h0), 1'b0);
        send_item(make_item(OP_MULHU, WORD_ONES, WORD_ONES, 20'h0), 1'b0);
        // I-type immediates at the edges of the 12-bit range and just past them.
        send_item(make_item(OP_ADDI, WORD_ONES, 64'd0, 20'h007ff), 1'b1);
        send_item(make_item(OP_ADDI, 64'd0, WORD_ONES, 20'hff800), 1'b0);
        send_item(make_item(OP_ADDI, WORD_MAX, 64'd0, 20'h00800), 1'b0);
        send_item(make_item(OP_ADDIW, 64'h0000_0000_7fff_ffff, 64'd0, 20'h00001), 1'b1);
        send_item(make_item(OP_ADDIW, WORD_MIN, 64'd0, 20'hff7ff), 1'b0);
        send_item(make_item(OP_ANDI, WORD_ONES, 64'd0, 20'h7ffff), 1'b0);
        send_item(make_item(OP_ANDI, WORD_ONES, 64'd0, 20'h80000), 1'b1);
        send_item(make_item(OP_ANDI, WORD_ONES, 64'd0, 20'hfffff), 1'b0);
        // Immediate shifts mask the amount to six bits and never flag.
        send_item(make_item(OP_SLLI, 64'd1, 64'd0, 20'hfffff), 1'b0);
        send_item(make_item(OP_SRLI, WORD_MIN, 64'd0, 20'h00040), 1'b1);
        send_item(make_item(OP_LUI, 64'd0, 64'd0, 20'h80000), 1'b0);
        send_item(make_item(OP_LUI, WORD_ONES, WORD_ONES, 20'h7ffff), 1'b0);
        directed_items = items_sent;
        drain();

        // Random items, with gap-free stretches between gapped ones.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            send_item(make_item(t_op'($urandom_range(0, 15)), rand_word(), rand_word(),
                                rand_immediate()), ((n / 200) % 3) != 1);
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items (%0d directed) across all sixteen operations.",
                 items_sent, directed_items);
        $display("Checked %0d results, %0d of them with the immediate range flag set.",
                 sb.checked, sb.flagged);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/rv64alu_pkg.sv
rtl/rv64alu_exec.sv
rtl/rv64alu_mul.sv
rtl/rv64_integer_alu.sv
verif/tb_rv64_integer_alu.sv
